>>> sv/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/gbsc_pkg.sv
// ---------------------------------------------------------------------------
// gbsc_pkg
// shared types and constants of the grid binned segment crossing counter
// ---------------------------------------------------------------------------
`default_nettype none
package gbsc_pkg;

   localparam int COORD_W = 32;
   localparam int COUNT_W = 19;
   localparam int CELLS_W = 9;
   localparam int EXT_W   = 31;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CELLS_X  = 2'd0,
      CSR_CELLS_Y  = 2'd1,
      CSR_X_EXTENT = 2'd2,
      CSR_Y_EXTENT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic                      last_segment;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] crossing_count;
      logic               overflow;
   } rsp_type;

endpackage
`default_nettype wire

>>> sv/grid_binned_segment_crossing_count.sv
// load: a segment is captured, scaled, divided and then stored in the ram
//   (one quotient bit a cycle in the two axis dividers)
// last segment: pair sweep over the store, reading each row and then each candidate
//   pair, with eight products per same-cell pair (one shared 33x33 multiplier)
// throughput: one segment per load time, result after the sweep; no reset sweep
// reset: synchronous, clears control, fill count and overflow; store left as is
// ---------------------------------------------------------------------------
// grid_binned_segment_crossing_count
// bins segments to grid cells in a ram and counts crossing same-cell pairs
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module grid_binned_segment_crossing_count #(
   parameter int MAX_SEGMENTS = 1024,
   parameter int MAX_CELLS_PER_AXIS = 256
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire gbsc_pkg::req_type          req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output gbsc_pkg::rsp_type               rsp_data,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [gbsc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [gbsc_pkg::CSR_DATA_W-1:0] csr_data
);
   import gbsc_pkg::*;

   localparam int AW = $clog2(MAX_SEGMENTS);
   localparam int FW = $clog2(MAX_SEGMENTS + 1);
   localparam int NW = $clog2(MAX_CELLS_PER_AXIS + 1);
   localparam int QB = (MAX_CELLS_PER_AXIS > 1) ? $clog2(MAX_CELLS_PER_AXIS) : 1;
   localparam int CW = 2 * QB;
   localparam int NUMW = EXT_W + NW;
   localparam int DW = 4 * COORD_W + CW;
   localparam int DIFW = COORD_W + 1;
   localparam int PW = 2 * DIFW;
   localparam int QCW = $clog2(QB + 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [3:0] K_LAST_OP = 4'd7;
   localparam logic [3:0] K_DECIDE = 4'd10;

   typedef enum logic [3:0] {
      S_IDLE, S_SCALE, S_DIV, S_STORE, S_RD_I, S_LAT_I, S_RD_J, S_LAT_J, S_MUL, S_DONE
   } state_type;

   state_type state_ff;

   // configuration
   logic [CELLS_W-1:0] cells_x_ff, cells_y_ff;
   logic [EXT_W-1:0]   x_extent_ff, y_extent_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_x_ff  <= CELLS_W'(16);
         cells_y_ff  <= CELLS_W'(16);
         x_extent_ff <= EXT_W'(65536);
         y_extent_ff <= EXT_W'(65536);
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_CELLS_X:  cells_x_ff  <= csr_data[CELLS_W-1:0];
            CSR_CELLS_Y:  cells_y_ff  <= csr_data[CELLS_W-1:0];
            CSR_X_EXTENT: x_extent_ff <= csr_data[EXT_W-1:0];
            CSR_Y_EXTENT: y_extent_ff <= csr_data[EXT_W-1:0];
            default: ;
         endcase
      end
   end

   function automatic logic [NW-1:0] eff_cells(input logic [CELLS_W-1:0] r);
      if (r == '0) return NW'(1);
      if (32'(r) > MAX_CELLS_PER_AXIS) return NW'(MAX_CELLS_PER_AXIS);
      return NW'(r);
   endfunction

   // segment being loaded
   req_type           seg_ff;
   logic [NW-1:0]     nx_ff, ny_ff;
   logic [EXT_W-1:0]  ex_ff, ey_ff;
   logic              xneg_ff, xbig_ff, yneg_ff, ybig_ff;
   logic [NUMW-1:0]   xnum_ff, ynum_ff;
   logic [COORD_W-1:0] xrem_ff, yrem_ff;
   logic [QB-1:0]     xq_ff, yq_ff;
   logic [QCW-1:0]    dcnt_ff;
   logic [FW-1:0]     fill_ff;
   logic              ovf_ff;

   // pair sweep
   logic [AW-1:0]     i_ff, j_ff;
   logic [DW-1:0]     seg_i_ff, seg_j_ff;
   logic [3:0]        k_ff;
   logic signed [DIFW-1:0] opa_ff, opb_ff;
   logic signed [PW-1:0]   prod_ff, p_ff;
   logic [3:0]        opos_ff, oneg_ff;
   logic [COUNT_W-1:0] count_ff;

   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;
   logic              rsp_load;

   // ram
   logic              wr_en;
   logic [AW-1:0]     rd_addr;
   logic [DW-1:0]     wr_data, rd_data;
   logic [EXT_W-1:0]  ex_eff, ey_eff;

   assign ex_eff = (x_extent_ff == '0) ? EXT_W'(1) : x_extent_ff;
   assign ey_eff = (y_extent_ff == '0) ? EXT_W'(1) : y_extent_ff;

   logic [QB-1:0] cx, cy;
   logic [CW-1:0] cell_idx;
   always_comb begin
      cx = xneg_ff ? '0 : (xbig_ff ? QB'(nx_ff - NW'(1)) : xq_ff);
      cy = yneg_ff ? '0 : (ybig_ff ? QB'(ny_ff - NW'(1)) : yq_ff);
      cell_idx = CW'(cx) + CW'(CW'(cy) * CW'(nx_ff));
   end

   assign wr_en   = (state_ff == S_STORE) && (fill_ff != FW'(MAX_SEGMENTS));
   assign wr_data = {cell_idx, seg_ff.end_y, seg_ff.end_x, seg_ff.start_y, seg_ff.start_x};
   assign rd_addr = (state_ff == S_RD_I) ? i_ff : j_ff;

   gbsc_ram #(.WIDTH(DW), .DEPTH(MAX_SEGMENTS)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(fill_ff[AW-1:0]),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // scaled coordinates
   logic [NUMW-1:0] xprod, yprod;
   assign xprod = NUMW'(seg_ff.start_x[COORD_W-2:0]) * NUMW'(nx_ff);
   assign yprod = NUMW'(seg_ff.start_y[COORD_W-2:0]) * NUMW'(ny_ff);

   // restoring divider steps
   logic [COORD_W-1:0] xt, yt;
   logic               xge, yge;
   always_comb begin
      xt  = {xrem_ff[COORD_W-2:0], xnum_ff[dcnt_ff - QCW'(1)]};
      yt  = {yrem_ff[COORD_W-2:0], ynum_ff[dcnt_ff - QCW'(1)]};
      xge = xt >= COORD_W'(ex_ff);
      yge = yt >= COORD_W'(ey_ff);
   end

   // entry fields
   logic signed [COORD_W-1:0] a0, b0, a1, b1, a2, b2, a3, b3;
   always_comb begin
      a0 = seg_i_ff[COORD_W-1:0];
      b0 = seg_i_ff[2*COORD_W-1:COORD_W];
      a1 = seg_i_ff[3*COORD_W-1:2*COORD_W];
      b1 = seg_i_ff[4*COORD_W-1:3*COORD_W];
      a2 = seg_j_ff[COORD_W-1:0];
      b2 = seg_j_ff[2*COORD_W-1:COORD_W];
      a3 = seg_j_ff[3*COORD_W-1:2*COORD_W];
      b3 = seg_j_ff[4*COORD_W-1:3*COORD_W];
   end

   // operand pairs of the eight orientation products
   logic signed [COORD_W-1:0] am, as, bm, bs;
   always_comb begin
      case (k_ff[2:0])
         3'd0: begin am = a2; as = a0; bm = b1; bs = b0; end
         3'd1: begin am = b2; as = b0; bm = a1; bs = a0; end
         3'd2: begin am = a3; as = a0; bm = b1; bs = b0; end
         3'd3: begin am = b3; as = b0; bm = a1; bs = a0; end
         3'd4: begin am = a0; as = a2; bm = b3; bs = b2; end
         3'd5: begin am = b0; as = b2; bm = a3; bs = a2; end
         3'd6: begin am = a1; as = a2; bm = b3; bs = b2; end
         default: begin am = b1; as = b2; bm = a3; bs = a2; end
      endcase
   end

   logic signed [PW:0] odiff;
   logic [3:0]         m;
   logic               crossing;
   assign odiff = {p_ff[PW-1], p_ff} - {prod_ff[PW-1], prod_ff};
   assign m = k_ff - 4'd2;
   assign crossing = ((opos_ff[0] & oneg_ff[1]) | (oneg_ff[0] & opos_ff[1])) &
                     ((opos_ff[2] & oneg_ff[3]) | (oneg_ff[2] & opos_ff[3]));

   // sweep advance
   logic more_j, more_i;
   assign more_j = (FW'(j_ff) + FW'(1)) < fill_ff;
   assign more_i = (FW'(i_ff) + FW'(2)) < fill_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  seg_ff  <= req_data;
                  nx_ff   <= eff_cells(cells_x_ff);
                  ny_ff   <= eff_cells(cells_y_ff);
                  ex_ff   <= ex_eff;
                  ey_ff   <= ey_eff;
                  xneg_ff <= req_data.start_x[COORD_W-1];
                  yneg_ff <= req_data.start_y[COORD_W-1];
                  xbig_ff <= req_data.start_x[COORD_W-2:0] >= ex_eff;
                  ybig_ff <= req_data.start_y[COORD_W-2:0] >= ey_eff;
                  state_ff <= S_SCALE;
               end
            end
            S_SCALE: begin
               // remainder starts from the high part of the product
               xnum_ff  <= xprod;
               ynum_ff  <= yprod;
               xrem_ff  <= COORD_W'(xprod >> QB);
               yrem_ff  <= COORD_W'(yprod >> QB);
               state_ff <= S_DIV;
               dcnt_ff  <= QCW'(QB);
            end
            S_DIV: begin
               xrem_ff <= xge ? xt - COORD_W'(ex_ff) : xt;
               yrem_ff <= yge ? yt - COORD_W'(ey_ff) : yt;
               xq_ff   <= QB'({xq_ff, xge});
               yq_ff   <= QB'({yq_ff, yge});
               dcnt_ff <= dcnt_ff - QCW'(1);
               if (dcnt_ff == QCW'(1)) begin
                  state_ff <= S_STORE;
               end
            end
            S_STORE: begin
               if (fill_ff != FW'(MAX_SEGMENTS)) begin
                  fill_ff <= fill_ff + FW'(1);
               end else begin
                  ovf_ff <= 1'b1;
               end
               if (seg_ff.last_segment) begin
                  i_ff     <= '0;
                  count_ff <= '0;
                  // fill before this store is at least the new fill minus one
                  if ((fill_ff != FW'(MAX_SEGMENTS) && fill_ff >= FW'(1)) ||
                      fill_ff >= FW'(2)) begin
                     state_ff <= S_RD_I;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_RD_I: begin
               state_ff <= S_LAT_I;
            end
            S_LAT_I: begin
               seg_i_ff <= rd_data;
               j_ff     <= i_ff + AW'(1);
               state_ff <= S_RD_J;
            end
            S_RD_J: begin
               state_ff <= S_LAT_J;
            end
            S_LAT_J: begin
               seg_j_ff <= rd_data;
               if (rd_data[DW-1:DW-CW] == seg_i_ff[DW-1:DW-CW]) begin
                  k_ff     <= '0;
                  state_ff <= S_MUL;
               end else if (more_j) begin
                  j_ff     <= j_ff + AW'(1);
                  state_ff <= S_RD_J;
               end else if (more_i) begin
                  i_ff     <= i_ff + AW'(1);
                  state_ff <= S_RD_I;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_MUL: begin
               k_ff <= k_ff + 4'd1;
               if (k_ff <= K_LAST_OP) begin
                  opa_ff <= DIFW'(am) - DIFW'(as);
                  opb_ff <= DIFW'(bm) - DIFW'(bs);
               end
               if (k_ff >= 4'd1 && k_ff <= 4'd8) begin
                  prod_ff <= opa_ff * opb_ff;
               end
               if (k_ff >= 4'd2 && k_ff <= 4'd9) begin
                  if (!m[0]) begin
                     p_ff <= prod_ff;
                  end else begin
                     opos_ff[m[2:1]] <= !odiff[PW] && (odiff != '0);
                     oneg_ff[m[2:1]] <= odiff[PW];
                  end
               end
               if (k_ff == K_DECIDE) begin
                  if (crossing && count_ff != COUNT_MAX) begin
                     count_ff <= count_ff + COUNT_W'(1);
                  end
                  if (more_j) begin
                     j_ff     <= j_ff + AW'(1);
                     state_ff <= S_RD_J;
                  end else if (more_i) begin
                     i_ff     <= i_ff + AW'(1);
                     state_ff <= S_RD_I;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_data_ff.crossing_count <= count_ff;
                  rsp_data_ff.overflow       <= ovf_ff;
                  fill_ff  <= '0;
                  ovf_ff   <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= FW'(MAX_SEGMENTS), "fill count beyond store depth")
   `ASSERT_IMPLY(a_pair_order, clock, reset, state_ff == S_MUL || state_ff == S_LAT_J, j_ff > i_ff, "pair indices out of order")
   `ASSERT_IMPLY(a_empty_after_rsp, clock, reset, $rose(rsp_valid_ff), fill_ff == '0 && !ovf_ff, "store not emptied with result")

endmodule
`default_nettype wire

>>> sv/gbsc_ram.sv
// ---------------------------------------------------------------------------
// gbsc_ram
// single write port, single read port ram with registered read data
// ---------------------------------------------------------------------------
`default_nettype none
module gbsc_ram #(
   parameter int WIDTH = 144,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
